// ===== rtl/gbns_pkg.sv =====
// ----------------------------------------------------------------------------
// gbns_pkg
// Shared types and codes for the grid-bucket nearest seed search block.
// ----------------------------------------------------------------------------
package gbns_pkg;

    // Field widths of one beat
    localparam int ACT_W   = 2;
    localparam int COORD_W = 11;
    localparam int TAG_W   = 24;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 7;
    localparam int ENTRY_W = TAG_W + 2 * COORD_W;
    // squared distance fits 2*COORD_W+1 bits; one spare bit for the bound
    localparam int DIST_W  = 2 * (COORD_W + 1);

    // Item actions
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd3;

    // Configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_item;
        logic              best_init;
        logic              clr_we;
        logic              fill_rd;
        logic              ins_write;
        logic              ent_rd;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             cell_in;
        logic             ins_oob;
        logic             fill_full;
        logic             found;
        logic             pipe_busy;
    } dp_stat_t;

endpackage

// ===== rtl/gbns_dp.sv =====
// ----------------------------------------------------------------------------
// gbns_dp
// Datapath: config registers, cell index divide, cell fill and entry memories,
// distance pipeline with best-seed tracking, and the result register.
// ----------------------------------------------------------------------------
module gbns_dp import gbns_pkg::*; #(
    parameter int CELL_SIZE     = 30,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_GRID_SIDE = 64,
    localparam int NCELLS = MAX_GRID_SIDE * MAX_GRID_SIDE,
    localparam int CAW    = $clog2(NCELLS),
    localparam int FW     = $clog2(CELL_CAPACITY + 1),
    localparam int KW     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1,
    localparam int SW     = $clog2(MAX_GRID_SIDE + 1),
    localparam int OW     = SW + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    // item payload
    input  logic [ACT_W-1:0]          in_action,
    input  logic [COORD_W-1:0]        in_x,
    input  logic [COORD_W-1:0]        in_y,
    input  logic [TAG_W-1:0]          in_tag,
    // controller link
    input  dp_cmd_t                   cmd,
    input  logic [CAW-1:0]            clr_addr,
    input  logic signed [OW-1:0]      ox,
    input  logic signed [OW-1:0]      oy,
    input  logic [KW-1:0]             k,
    output dp_stat_t                  stat,
    output logic [FW-1:0]             fill_n,
    output logic [SW-1:0]             cols_eff,
    // result payload
    output logic [STAT_W-1:0]         res_status,
    output logic [3*COORD_W+2-1+TAG_W-COORD_W:0] res_data
);

    localparam int NENT  = NCELLS * CELL_CAPACITY;
    localparam int EAW   = $clog2(NENT);
    localparam int XW    = $clog2(MAX_GRID_SIDE);
    localparam int CW    = ((OW > COORD_W + 1) ? OW : COORD_W + 1) + 1;
    localparam int DIV_S = COORD_W + 1;
    localparam int DIV_M = (1 << DIV_S) / CELL_SIZE;
    localparam int MW    = DIV_S + 1;
    localparam int PW    = COORD_W + MW;
    localparam int CS2   = CELL_SIZE * CELL_SIZE;
    localparam int CS2W  = $clog2(CS2 + 1);
    localparam int HB    = DIST_W / 2;
    localparam int BW    = ((2 * SW + CS2W) > HB + 1) ? 2 * SW + CS2W : HB + 1;
    localparam int RDW   = 3 * COORD_W + 2 - 1 + TAG_W - COORD_W + 1;

    // Configuration registers, saturated to the grid limit
    logic [CFG_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [SW-1:0]    rows_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= CFG_W'(64);
            rows_cfg_reg <= CFG_W'(64);
        end else if (cfg_valid) begin
            if (cfg_index == REG_COLUMNS) cols_cfg_reg <= cfg_data;
            if (cfg_index == REG_ROWS)    rows_cfg_reg <= cfg_data;
        end
    end

    always_comb begin
        cols_eff = (32'(cols_cfg_reg) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE)
                                                       : SW'(cols_cfg_reg);
        rows_eff = (32'(rows_cfg_reg) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE)
                                                       : SW'(rows_cfg_reg);
    end

    // Item capture
    logic [ACT_W-1:0]   act_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [TAG_W-1:0]   tag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= in_action;
            px_reg  <= in_x;
            py_reg  <= in_y;
            tag_reg <= in_tag;
        end
    end

    // Cell index: reciprocal multiply, then one correction step
    logic [PW-1:0]      qx_prod_reg, qy_prod_reg;
    logic [2*SW-1:0]    area_reg;
    logic [COORD_W-1:0] qx_est, qy_est, rx, ry;
    logic [COORD_W-1:0] bx_reg, by_reg;
    logic [BW-1:0]      b_reg;

    always_comb begin
        qx_est = COORD_W'(qx_prod_reg >> DIV_S);
        qy_est = COORD_W'(qy_prod_reg >> DIV_S);
        rx = px_reg - COORD_W'(PW'(qx_est) * PW'(CELL_SIZE));
        ry = py_reg - COORD_W'(PW'(qy_est) * PW'(CELL_SIZE));
    end

    always_ff @(posedge aclk) begin
        qx_prod_reg <= PW'(px_reg) * PW'(DIV_M);
        qy_prod_reg <= PW'(py_reg) * PW'(DIV_M);
        area_reg    <= (2*SW)'(cols_eff) * (2*SW)'(rows_eff);
        bx_reg <= qx_est + COORD_W'(32'(rx) >= CELL_SIZE);
        by_reg <= qy_est + COORD_W'(32'(ry) >= CELL_SIZE);
        b_reg  <= BW'(area_reg) * BW'(CS2);
    end

    // Distance bound: b squared, saturated above any reachable distance
    logic [DIST_W-1:0] limit;
    assign limit = (b_reg[BW-1:HB] != '0) ? '1 : b_reg[HB-1:0] * b_reg[HB-1:0];

    // Cell address of base plus offset, with grid bounds check
    logic signed [CW-1:0] cx, cy;
    logic [CAW-1:0]       cell_addr;

    always_comb begin
        cx = $signed({{(CW-COORD_W){1'b0}}, bx_reg}) + CW'(ox);
        cy = $signed({{(CW-COORD_W){1'b0}}, by_reg}) + CW'(oy);
        cell_addr = CAW'(CAW'(cy[XW-1:0]) * CAW'(MAX_GRID_SIDE)) + CAW'(cx[XW-1:0]);
    end

    assign stat.cell_in = !cx[CW-1] && !cy[CW-1]
                       && (cx < $signed({{(CW-SW){1'b0}}, cols_eff}))
                       && (cy < $signed({{(CW-SW){1'b0}}, rows_eff}));
    assign stat.ins_oob = (32'(bx_reg) >= 32'(cols_eff)) || (32'(by_reg) >= 32'(rows_eff));

    // Cell fill memory
    logic [FW-1:0]  fill_mem [NCELLS];
    logic [FW-1:0]  fill_q;
    logic [CAW-1:0] cell_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr_we) begin
            fill_mem[clr_addr] <= '0;
        end else if (cmd.ins_write) begin
            fill_mem[cell_reg] <= fill_q + FW'(1);
        end
        if (cmd.fill_rd) begin
            fill_q   <= fill_mem[cell_addr];
            cell_reg <= cell_addr;
        end
    end

    assign fill_n         = fill_q;
    assign stat.fill_full = (32'(fill_q) >= CELL_CAPACITY);

    // Entry memory: {tag, y, x} per slot
    logic [ENTRY_W-1:0] ent_mem [NENT];
    logic [ENTRY_W-1:0] ent_q;
    logic [EAW-1:0]     ent_base, wr_addr, rd_addr;

    always_comb begin
        ent_base = EAW'(EAW'(cell_reg) * EAW'(CELL_CAPACITY));
        wr_addr  = ent_base + EAW'(fill_q);
        rd_addr  = ent_base + EAW'(k);
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_write) ent_mem[wr_addr] <= {tag_reg, py_reg, px_reg};
        if (cmd.ent_rd)    ent_q <= ent_mem[rd_addr];
    end

    // Distance pipeline: read data, abs differences, squares, compare
    logic                 v1_reg, v2_reg, v3_reg;
    logic [COORD_W-1:0]   ex, ey;
    logic [COORD_W-1:0]   dx_reg, dy_reg, ex2_reg, ey2_reg, ex3_reg, ey3_reg;
    logic [TAG_W-1:0]     et2_reg, et3_reg;
    logic [2*COORD_W-1:0] dx2_reg, dy2_reg;
    logic [DIST_W-1:0]    d2;

    assign ex = ent_q[COORD_W-1:0];
    assign ey = ent_q[2*COORD_W-1:COORD_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.ent_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= (px_reg > ex) ? px_reg - ex : ex - px_reg;
        dy_reg  <= (py_reg > ey) ? py_reg - ey : ey - py_reg;
        ex2_reg <= ex;
        ey2_reg <= ey;
        et2_reg <= ent_q[ENTRY_W-1:2*COORD_W];
        dx2_reg <= dx_reg * dx_reg;
        dy2_reg <= dy_reg * dy_reg;
        ex3_reg <= ex2_reg;
        ey3_reg <= ey2_reg;
        et3_reg <= et2_reg;
    end

    assign d2             = DIST_W'(dx2_reg) + DIST_W'(dy2_reg);
    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg;

    // Best seed so far; strictly closer wins
    logic [DIST_W-1:0]  best_reg;
    logic               found_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic [TAG_W-1:0]   stag_reg;
    logic [STAT_W-1:0]  status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            found_reg <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            stag_reg  <= '0;
        end else if (v3_reg && (d2 < best_reg)) begin
            found_reg <= 1'b1;
            sx_reg    <= ex3_reg;
            sy_reg    <= ey3_reg;
            stag_reg  <= et3_reg;
        end
        if (cmd.best_init) begin
            best_reg <= limit;
        end else if (v3_reg && (d2 < best_reg)) begin
            best_reg <= d2;
        end
        if (cmd.load_item) begin
            status_reg <= ST_OK;
        end else if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
    end

    assign stat.found  = found_reg;
    assign stat.action = act_reg;

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_status <= status_reg;
            res_data   <= RDW'({stag_reg, sy_reg, sx_reg});
        end
    end

endmodule

// ===== rtl/gbns_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbns_ctrl
// Controller: clearing sweep, item dispatch, cell scan order of the query
// (3x3 block, then rings), and the result handshake.
// ----------------------------------------------------------------------------
module gbns_ctrl import gbns_pkg::*; #(
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_GRID_SIDE = 64,
    localparam int NCELLS = MAX_GRID_SIDE * MAX_GRID_SIDE,
    localparam int CAW    = $clog2(NCELLS),
    localparam int FW     = $clog2(CELL_CAPACITY + 1),
    localparam int KW     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1,
    localparam int SW     = $clog2(MAX_GRID_SIDE + 1),
    localparam int OW     = SW + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dp_stat_t             stat,
    input  logic [FW-1:0]        fill_n,
    input  logic [SW-1:0]        cols_eff,
    output dp_cmd_t              cmd,
    output logic [CAW-1:0]       clr_addr,
    output logic signed [OW-1:0] ox,
    output logic signed [OW-1:0] oy,
    output logic [KW-1:0]        k
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIV1    = 4'd2;
    localparam logic [3:0] S_DIV2    = 4'd3;
    localparam logic [3:0] S_DIV3    = 4'd4;
    localparam logic [3:0] S_INS_WR  = 4'd5;
    localparam logic [3:0] S_Q_CELL  = 4'd6;
    localparam logic [3:0] S_Q_FILL  = 4'd7;
    localparam logic [3:0] S_Q_ENT   = 4'd8;
    localparam logic [3:0] S_Q_DRAIN = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // scan phases
    localparam logic [1:0] P_BLOCK = 2'd0;
    localparam logic [1:0] P_ROWS  = 2'd1;
    localparam logic [1:0] P_SIDES = 2'd2;

    localparam logic signed [OW-1:0] ONE_S  = OW'(1);
    localparam logic signed [OW-1:0] NEG1_S = -OW'(1);

    logic [3:0]           state_reg, state_next;
    logic [CAW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                 clr_item_reg, clr_item_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic signed [OW-1:0] a_reg, a_next, b_reg, b_next;
    logic                 tb_reg, tb_next, side_reg, side_next;
    logic [1:0]           phase_reg, phase_next;
    logic [SW-1:0]        d_reg, d_next;
    logic [KW-1:0]        k_reg, k_next;

    // adv_* is where the scan order goes after the current cell
    logic signed [OW-1:0] ds, dm1s;
    logic signed [OW-1:0] adv_a, adv_b;
    logic                 adv_tb, adv_side, adv_end;
    logic [1:0]           adv_phase;
    logic [SW-1:0]        d_inc;

    always_comb begin
        ds   = $signed({1'b0, d_reg});
        dm1s = ds - ONE_S;
        d_inc = d_reg + SW'(1);
    end

    // Offset of the cell being scanned
    always_comb begin
        case (phase_reg)
            P_ROWS: begin
                ox = a_reg;
                oy = tb_reg ? ds : -ds;
            end
            P_SIDES: begin
                ox = side_reg ? dm1s : -dm1s;
                oy = b_reg;
            end
            default: begin
                ox = a_reg;
                oy = b_reg;
            end
        endcase
        if (state_reg == S_DIV3) begin
            ox = '0;
            oy = '0;
        end
    end

    // Step of the scan order
    always_comb begin
        adv_a     = a_reg;
        adv_b     = b_reg;
        adv_tb    = tb_reg;
        adv_side  = side_reg;
        adv_phase = phase_reg;
        adv_end   = 1'b0;
        case (phase_reg)
            P_ROWS: begin
                if (!tb_reg) begin
                    adv_tb = 1'b1;
                end else begin
                    adv_tb = 1'b0;
                    if (a_reg < ds) begin
                        adv_a = a_reg + ONE_S;
                    end else begin
                        adv_phase = P_SIDES;
                        adv_side  = 1'b0;
                        adv_b     = -dm1s;
                    end
                end
            end
            P_SIDES: begin
                if (b_reg < dm1s) begin
                    adv_b = b_reg + ONE_S;
                end else if (!side_reg) begin
                    adv_side = 1'b1;
                    adv_b    = -dm1s;
                end else begin
                    adv_end = 1'b1;
                end
            end
            default: begin
                if (b_reg < ONE_S) begin
                    adv_b = b_reg + ONE_S;
                end else begin
                    adv_b = NEG1_S;
                    if (a_reg < ONE_S) adv_a = a_reg + ONE_S;
                    else adv_end = 1'b1;
                end
            end
        endcase
    end

    // Main state machine
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_item_next = clr_item_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        tb_next       = tb_reg;
        side_next     = side_reg;
        phase_next    = phase_reg;
        d_next        = d_reg;
        k_next        = k_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_CLR: begin
                cmd.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + CAW'(1);
                if (clr_cnt_reg == CAW'(NCELLS - 1)) begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1: state_next = S_DIV2;
            S_DIV2: state_next = S_DIV3;
            S_DIV3: begin
                case (stat.action)
                    ACT_CLEAR: begin
                        clr_item_next = 1'b1;
                        state_next    = S_CLR;
                    end
                    ACT_INSERT: begin
                        if (stat.ins_oob) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_OUTSIDE;
                            state_next      = S_DONE;
                        end else begin
                            cmd.fill_rd = 1'b1;
                            state_next  = S_INS_WR;
                        end
                    end
                    ACT_QUERY: begin
                        cmd.best_init = 1'b1;
                        phase_next    = P_BLOCK;
                        a_next        = NEG1_S;
                        b_next        = NEG1_S;
                        d_next        = SW'(1);
                        state_next    = S_Q_CELL;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_INS_WR: begin
                if (stat.fill_full) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                end else begin
                    cmd.ins_write = 1'b1;
                end
                state_next = S_DONE;
            end
            S_Q_CELL: begin
                k_next = '0;
                if (stat.cell_in) begin
                    cmd.fill_rd = 1'b1;
                    state_next  = S_Q_FILL;
                end else begin
                    a_next     = adv_a;
                    b_next     = adv_b;
                    tb_next    = adv_tb;
                    side_next  = adv_side;
                    phase_next = adv_phase;
                    state_next = adv_end ? S_Q_DRAIN : S_Q_CELL;
                end
            end
            S_Q_FILL, S_Q_ENT: begin
                if (fill_n == '0) begin
                    a_next     = adv_a;
                    b_next     = adv_b;
                    tb_next    = adv_tb;
                    side_next  = adv_side;
                    phase_next = adv_phase;
                    state_next = adv_end ? S_Q_DRAIN : S_Q_CELL;
                end else begin
                    cmd.ent_rd = 1'b1;
                    if (FW'(k_reg) + FW'(1) == fill_n) begin
                        a_next     = adv_a;
                        b_next     = adv_b;
                        tb_next    = adv_tb;
                        side_next  = adv_side;
                        phase_next = adv_phase;
                        state_next = adv_end ? S_Q_DRAIN : S_Q_CELL;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_Q_ENT;
                    end
                end
            end
            S_Q_DRAIN: begin
                if (!stat.pipe_busy) begin
                    if (stat.found) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_OK;
                        state_next      = S_DONE;
                    end else if (d_inc < cols_eff) begin
                        d_next     = d_inc;
                        phase_next = P_ROWS;
                        a_next     = -$signed({1'b0, d_inc});
                        tb_next    = 1'b0;
                        state_next = S_Q_CELL;
                    end else begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NONE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            tb_reg       <= 1'b0;
            side_reg     <= 1'b0;
            phase_reg    <= P_BLOCK;
            d_reg        <= '0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            m_tvalid_reg <= m_tvalid_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            tb_reg       <= tb_next;
            side_reg     <= side_next;
            phase_reg    <= phase_next;
            d_reg        <= d_next;
            k_reg        <= k_next;
        end
    end

    assign clr_addr = clr_cnt_reg;
    assign k        = k_reg;
    assign m_tvalid = m_tvalid_reg;

    // Checks
    a_accept_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DIV1))
        else $error("accepted beat did not start the divide");

    a_mem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_we, cmd.ins_write, cmd.fill_rd, cmd.ent_rd}))
        else $error("conflicting memory commands");

    a_ent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ent_rd |-> (FW'(k_reg) < fill_n))
        else $error("entry read beyond cell fill");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten while still pending");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_Q_DRAIN && state_next != S_Q_DRAIN) |-> !stat.pipe_busy)
        else $error("ring decision taken with distances in flight");

endmodule

// ===== rtl/grid_bucket_nearest_seed.sv =====
// ----------------------------------------------------------------------------
// grid_bucket_nearest_seed
// Seed store bucketed into square cells with approximate nearest-seed query.
// ----------------------------------------------------------------------------
// One item at a time. After reset, and for every clear item, the block sweeps
// all MAX_GRID_SIDE squared cells (4096 by default) of the cell fill memory one
// cell per cycle with s_tready low. A query first finds the cell of its point,
// then visits the cells in scan order: a cell outside the grid is skipped, and a
// cell inside it has its fill read, then one entry read per stored seed (the
// entry memory read port gives one seed per cycle). The distance pipeline is
// drained after the 3x3 block and after each ring. Each result sits in an
// output register until m_tready takes it.
module grid_bucket_nearest_seed import gbns_pkg::*; #(
    parameter int CELL_SIZE     = 30,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_GRID_SIDE = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // coord_x, coord_y, seed_tag_in, 2'b0
    input  logic [ACT_W-1:0]  s_tuser,   // action
    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // seed_x, seed_y, seed_tag_out, 2'b0
    output logic [STAT_W-1:0] m_tuser,   // status
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int CAW = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE);
    localparam int FW  = $clog2(CELL_CAPACITY + 1);
    localparam int KW  = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int SW  = $clog2(MAX_GRID_SIDE + 1);
    localparam int OW  = SW + 1;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [CAW-1:0]       clr_addr;
    logic signed [OW-1:0] ox, oy;
    logic [KW-1:0]        k;
    logic [FW-1:0]        fill_n;
    logic [SW-1:0]        cols_eff;

    gbns_ctrl #(
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .fill_n   (fill_n),
        .cols_eff (cols_eff),
        .cmd      (cmd),
        .clr_addr (clr_addr),
        .ox       (ox),
        .oy       (oy),
        .k        (k)
    );

    gbns_dp #(
        .CELL_SIZE     (CELL_SIZE),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_action  (s_tuser),
        .in_x       (s_tdata[COORD_W-1:0]),
        .in_y       (s_tdata[2*COORD_W-1:COORD_W]),
        .in_tag     (s_tdata[ENTRY_W-1:2*COORD_W]),
        .cmd        (cmd),
        .clr_addr   (clr_addr),
        .ox         (ox),
        .oy         (oy),
        .k          (k),
        .stat       (stat),
        .fill_n     (fill_n),
        .cols_eff   (cols_eff),
        .res_status (m_tuser),
        .res_data   (m_tdata)
    );

endmodule
